// File: src/r2ss_pkg.sv
`default_nettype none
package r2ss_pkg;

	localparam int DW       = 64;
	localparam int RF_DEPTH = 32;
	localparam int RF_AW    = 5;

	typedef struct packed {
		logic signed [7:0] a1_num;
		logic [6:0]        a1_den;
		logic signed [7:0] b1_num;
		logic [6:0]        b1_den;
		logic signed [7:0] c1_num;
		logic [6:0]        c1_den;
		logic signed [7:0] a2_num;
		logic [6:0]        a2_den;
		logic signed [7:0] b2_num;
		logic [6:0]        b2_den;
		logic signed [7:0] c2_num;
		logic [6:0]        c2_den;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] x_num;
		logic [30:0]        x_den;
		logic signed [31:0] y_num;
		logic [30:0]        y_den;
		logic [1:0]         kind;
		logic               overflow;
	} out_item_t;

	localparam logic [1:0] KIND_UNIQUE   = 2'd0;
	localparam logic [1:0] KIND_PARALLEL = 2'd1;
	localparam logic [1:0] KIND_SAME     = 2'd2;

	// datapath operations
	localparam logic [2:0] OP_LOAD = 3'd0;
	localparam logic [2:0] OP_MUL  = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_RED  = 3'd3;
	localparam logic [2:0] OP_WRAP = 3'd4;
	localparam logic [2:0] OP_CAPY = 3'd5;
	localparam logic [2:0] OP_CAPX = 3'd6;

	// register file slots
	localparam logic [RF_AW-1:0] A1N = 5'd0;
	localparam logic [RF_AW-1:0] A1D = 5'd1;
	localparam logic [RF_AW-1:0] B1N = 5'd2;
	localparam logic [RF_AW-1:0] B1D = 5'd3;
	localparam logic [RF_AW-1:0] C1N = 5'd4;
	localparam logic [RF_AW-1:0] C1D = 5'd5;
	localparam logic [RF_AW-1:0] A2N = 5'd6;
	localparam logic [RF_AW-1:0] A2D = 5'd7;
	localparam logic [RF_AW-1:0] B2N = 5'd8;
	localparam logic [RF_AW-1:0] B2D = 5'd9;
	localparam logic [RF_AW-1:0] C2N = 5'd10;
	localparam logic [RF_AW-1:0] C2D = 5'd11;
	localparam logic [RF_AW-1:0] PN  = 5'd12;
	localparam logic [RF_AW-1:0] PD  = 5'd13;
	localparam logic [RF_AW-1:0] QN  = 5'd14;
	localparam logic [RF_AW-1:0] QD  = 5'd15;
	localparam logic [RF_AW-1:0] TN  = 5'd16;
	localparam logic [RF_AW-1:0] TD  = 5'd17;
	localparam logic [RF_AW-1:0] BN  = 5'd18;
	localparam logic [RF_AW-1:0] BD  = 5'd19;
	localparam logic [RF_AW-1:0] YN  = 5'd20;
	localparam logic [RF_AW-1:0] YD  = 5'd21;
	localparam logic [RF_AW-1:0] RYN = 5'd22;
	localparam logic [RF_AW-1:0] RYD = 5'd23;
	localparam logic [RF_AW-1:0] XN  = 5'd24;
	localparam logic [RF_AW-1:0] XD  = 5'd25;
	localparam logic [RF_AW-1:0] T1  = 5'd26;
	localparam logic [RF_AW-1:0] T2  = 5'd27;

	localparam int N_LOAD = 12;
	localparam logic [5:0] LAST_STEP = 6'd50;

	typedef struct packed {
		logic [2:0]       op;
		logic [RF_AW-1:0] ra;
		logic [RF_AW-1:0] rb;
		logic [RF_AW-1:0] wa;
	} uop_t;

	typedef struct packed {
		logic start;
		logic capture;
		uop_t uop;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
	} dp_stat_t;

	function automatic uop_t mk(input logic [2:0] op, input logic [RF_AW-1:0] ra,
			input logic [RF_AW-1:0] rb, input logic [RF_AW-1:0] wa);
		uop_t u;
		u.op = op;
		u.ra = ra;
		u.rb = rb;
		u.wa = wa;
		return u;
	endfunction

	// micro-program: operand loads, then y by Cramer, then x by back-substitution, then result capture
	function automatic uop_t r2ss_prog(input logic [5:0] step);
		uop_t u;
		logic [5:0] idx;
		idx = step - 6'(N_LOAD);
		u = mk(OP_LOAD, A1N, A1N, step[RF_AW-1:0]);
		if (step >= 6'(N_LOAD)) begin
			case (idx)
				6'd0:  u = mk(OP_MUL,  A2N, C1N, PN);
				6'd1:  u = mk(OP_MUL,  C1D, A2D, PD);
				6'd2:  u = mk(OP_RED,  PN,  PD,  PN);
				6'd3:  u = mk(OP_MUL,  A1N, C2N, QN);
				6'd4:  u = mk(OP_MUL,  A1D, C2D, QD);
				6'd5:  u = mk(OP_RED,  QN,  QD,  QN);
				6'd6:  u = mk(OP_MUL,  PN,  QD,  T1);
				6'd7:  u = mk(OP_MUL,  QN,  PD,  T2);
				6'd8:  u = mk(OP_SUB,  T1,  T2,  TN);
				6'd9:  u = mk(OP_MUL,  PD,  QD,  TD);
				6'd10: u = mk(OP_RED,  TN,  TD,  TN);
				6'd11: u = mk(OP_MUL,  B1N, A2N, PN);
				6'd12: u = mk(OP_MUL,  B1D, A2D, PD);
				6'd13: u = mk(OP_RED,  PN,  PD,  PN);
				6'd14: u = mk(OP_MUL,  A1N, B2N, QN);
				6'd15: u = mk(OP_MUL,  A1D, B2D, QD);
				6'd16: u = mk(OP_RED,  QN,  QD,  QN);
				6'd17: u = mk(OP_MUL,  PN,  QD,  T1);
				6'd18: u = mk(OP_MUL,  QN,  PD,  T2);
				6'd19: u = mk(OP_SUB,  T1,  T2,  BN);
				6'd20: u = mk(OP_MUL,  PD,  QD,  BD);
				6'd21: u = mk(OP_RED,  BN,  BD,  BN);
				6'd22: u = mk(OP_MUL,  TN,  BD,  YN);
				6'd23: u = mk(OP_MUL,  TD,  BN,  YD);
				6'd24: u = mk(OP_RED,  YN,  YD,  YN);
				6'd25: u = mk(OP_WRAP, YN,  YD,  YN);
				6'd26: u = mk(OP_MUL,  B1N, YN,  RYN);
				6'd27: u = mk(OP_MUL,  B1D, YD,  RYD);
				6'd28: u = mk(OP_RED,  RYN, RYD, RYN);
				6'd29: u = mk(OP_MUL,  C1N, RYD, T1);
				6'd30: u = mk(OP_MUL,  C1D, RYN, T2);
				6'd31: u = mk(OP_SUB,  T1,  T2,  T1);
				6'd32: u = mk(OP_MUL,  A1D, T1,  XN);
				6'd33: u = mk(OP_MUL,  A1N, C1D, T2);
				6'd34: u = mk(OP_MUL,  T2,  RYD, XD);
				6'd35: u = mk(OP_RED,  XN,  XD,  XN);
				6'd36: u = mk(OP_WRAP, XN,  XD,  XN);
				6'd37: u = mk(OP_CAPY, YN,  YD,  YN);
				6'd38: u = mk(OP_CAPX, XN,  XD,  XN);
				default: u = mk(OP_CAPX, XN, XD, XN);
			endcase
		end
		return u;
	endfunction

endpackage
`default_nettype wire

// File: src/r2ss_ram.sv
`default_nettype none
module r2ss_ram #(
	parameter int W = 64,
	parameter int D = 32
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr_a,
	output logic      [W-1:0]         rdata_a,
	input  wire logic [$clog2(D)-1:0] raddr_b,
	output logic      [W-1:0]         rdata_b
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule
`default_nettype wire

// File: src/r2ss_dp.sv
`default_nettype none
module r2ss_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire r2ss_pkg::in_item_t in_data,
	input  wire r2ss_pkg::dp_cmd_t  cmd,
	output r2ss_pkg::dp_stat_t      stat,
	output r2ss_pkg::out_item_t     out_data
);
	import r2ss_pkg::*;

	localparam logic [2:0] D_IDLE = 3'd0;
	localparam logic [2:0] D_RD   = 3'd1;
	localparam logic [2:0] D_EX   = 3'd2;
	localparam logic [2:0] D_MUL  = 3'd3;
	localparam logic [2:0] D_GCD  = 3'd4;
	localparam logic [2:0] D_DIV  = 3'd5;
	localparam logic [2:0] D_WN   = 3'd6;
	localparam logic [2:0] D_WD   = 3'd7;

	logic [2:0]    st_q;
	uop_t          uop_q;
	in_item_t      item_q;
	out_item_t     out_q;
	logic          y_dz_q;
	logic          ovf_q;
	logic          neg_q;
	logic [DW-1:0] qn_q, qd_q;
	logic [DW-1:0] rmn_q, rmd_q;
	logic [DW-1:0] ga_q, gb_q, dv_q;
	logic [5:0]    gk_q, cnt_q;
	logic [1:0]    mph_q;
	logic [DW-1:0] opa_q, opb_q, acc_q, prod_q;

	logic [DW-1:0] rda, rdb;
	logic          we_c;
	logic [RF_AW-1:0] waddr_c;
	logic [DW-1:0] wdata_c;
	logic [31:0]   mx_c, my_c;
	logic [DW-1:0] prod_c, mul_res_c;
	logic [DW-1:0] abs_a_c, abs_b_c;
	logic          g_fin_c;
	logic [DW-1:0] g_val_c;
	logic [2*DW-1:0] dstep_n_c, dstep_d_c;

	r2ss_ram #(.W(DW), .D(RF_DEPTH)) u_rf (
		.clk     (clk),
		.we      (we_c),
		.waddr   (waddr_c),
		.wdata   (wdata_c),
		.raddr_a (uop_q.ra),
		.rdata_a (rda),
		.raddr_b (uop_q.rb),
		.rdata_b (rdb)
	);

	function automatic logic [DW-1:0] load_val(input in_item_t it, input logic [RF_AW-1:0] a);
		logic [DW-1:0] v;
		case (a)
			A1N: v = {{56{it.a1_num[7]}}, it.a1_num};
			A1D: v = {57'b0, it.a1_den};
			B1N: v = {{56{it.b1_num[7]}}, it.b1_num};
			B1D: v = {57'b0, it.b1_den};
			C1N: v = {{56{it.c1_num[7]}}, it.c1_num};
			C1D: v = {57'b0, it.c1_den};
			A2N: v = {{56{it.a2_num[7]}}, it.a2_num};
			A2D: v = {57'b0, it.a2_den};
			B2N: v = {{56{it.b2_num[7]}}, it.b2_num};
			B2D: v = {57'b0, it.b2_den};
			C2N: v = {{56{it.c2_num[7]}}, it.c2_num};
			C2D: v = {57'b0, it.c2_den};
			default: v = '0;
		endcase
		return v;
	endfunction

	// one restoring division step; returns {remainder, quotient}
	function automatic logic [2*DW-1:0] div_step(input logic [DW-1:0] rem,
			input logic [DW-1:0] quo, input logic [DW-1:0] d);
		logic [DW:0] t;
		logic        b;
		t = {rem, quo[DW-1]};
		b = (t >= {1'b0, d});
		if (b) begin
			t = t - {1'b0, d};
		end
		return {t[DW-1:0], quo[DW-2:0], b};
	endfunction

	always_comb begin
		case (mph_q)
			2'd0:    begin mx_c = opa_q[31:0];  my_c = opb_q[31:0];  end
			2'd1:    begin mx_c = opa_q[31:0];  my_c = opb_q[63:32]; end
			default: begin mx_c = opa_q[63:32]; my_c = opb_q[31:0];  end
		endcase
		prod_c    = 64'(mx_c) * 64'(my_c);
		mul_res_c = acc_q + {prod_q[31:0], 32'b0};
		abs_a_c   = rda[DW-1] ? -rda : rda;
		abs_b_c   = rdb[DW-1] ? -rdb : rdb;
		g_fin_c   = (ga_q == '0) || (gb_q == '0);
		g_val_c   = ((ga_q == '0) ? gb_q : ga_q) << gk_q;
		dstep_n_c = div_step(rmn_q, qn_q, dv_q);
		dstep_d_c = div_step(rmd_q, qd_q, dv_q);
	end

	always_comb begin
		we_c      = 1'b0;
		waddr_c   = uop_q.wa;
		wdata_c   = mul_res_c;
		stat.done = 1'b0;
		case (st_q)
			D_EX: begin
				case (uop_q.op)
					OP_LOAD: begin
						we_c      = 1'b1;
						wdata_c   = load_val(item_q, uop_q.wa);
						stat.done = 1'b1;
					end
					OP_SUB: begin
						we_c      = 1'b1;
						wdata_c   = rda - rdb;
						stat.done = 1'b1;
					end
					OP_CAPY, OP_CAPX: stat.done = 1'b1;
					default: ;
				endcase
			end
			D_MUL: begin
				if (mph_q == 2'd3) begin
					we_c      = 1'b1;
					stat.done = 1'b1;
				end
			end
			D_WN: begin
				we_c    = 1'b1;
				waddr_c = uop_q.ra;
				wdata_c = neg_q ? -qn_q : qn_q;
			end
			D_WD: begin
				we_c      = 1'b1;
				waddr_c   = uop_q.rb;
				wdata_c   = qd_q;
				stat.done = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= D_IDLE;
			ovf_q <= 1'b0;
		end else begin
			case (st_q)
				D_IDLE: begin
					if (cmd.start) begin
						st_q <= D_RD;
					end
				end
				D_RD: st_q <= D_EX;
				D_EX: begin
					case (uop_q.op)
						OP_MUL:  st_q <= D_MUL;
						OP_RED:  st_q <= (abs_b_c == '0) ? D_WN : D_GCD;
						OP_WRAP: begin
							st_q <= D_WN;
							if ((|rda[63:31] && !(&rda[63:31])) ||
									(!rdb[63] && |rdb[62:31])) begin
								ovf_q <= 1'b1;
							end
						end
						OP_LOAD: begin
							st_q <= D_IDLE;
							if (uop_q.wa == A1N) begin
								ovf_q <= 1'b0;
							end
						end
						default: st_q <= D_IDLE;
					endcase
				end
				D_MUL: begin
					if (mph_q == 2'd3) begin
						st_q <= D_IDLE;
					end
				end
				D_GCD: begin
					if (g_fin_c) begin
						st_q <= D_DIV;
					end
				end
				D_DIV: begin
					if (cnt_q == '0) begin
						st_q <= D_WN;
					end
				end
				D_WN: st_q <= D_WD;
				D_WD: st_q <= D_IDLE;
				default: st_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_data;
		end
		if (st_q == D_IDLE && cmd.start) begin
			uop_q <= cmd.uop;
		end
		case (st_q)
			D_EX: begin
				opa_q <= rda;
				opb_q <= rdb;
				mph_q <= 2'd0;
				case (uop_q.op)
					OP_RED: begin
						neg_q <= rda[DW-1] ^ rdb[DW-1];
						qn_q  <= abs_a_c;
						qd_q  <= abs_b_c;
						ga_q  <= abs_a_c;
						gb_q  <= abs_b_c;
						gk_q  <= '0;
					end
					OP_WRAP: begin
						neg_q <= 1'b0;
						qn_q  <= {{32{rda[31]}}, rda[31:0]};
						qd_q  <= {{32{rdb[31]}}, rdb[31:0]};
					end
					OP_CAPY: begin
						out_q.y_num <= rda[31:0];
						out_q.y_den <= rdb[30:0];
						y_dz_q      <= (rdb[31:0] == '0);
					end
					OP_CAPX: begin
						out_q.x_num    <= rda[31:0];
						out_q.x_den    <= rdb[30:0];
						out_q.overflow <= ovf_q;
						if (rdb[31:0] == '0 && y_dz_q) begin
							out_q.kind <= (rda[31:0] == '0 && out_q.y_num == '0) ?
								KIND_SAME : KIND_PARALLEL;
						end else begin
							out_q.kind <= KIND_UNIQUE;
						end
					end
					default: ;
				endcase
			end
			D_MUL: begin
				mph_q  <= mph_q + 2'd1;
				prod_q <= prod_c;
				if (mph_q == 2'd1) begin
					acc_q <= prod_q;
				end else if (mph_q == 2'd2) begin
					acc_q <= mul_res_c;
				end
			end
			D_GCD: begin
				// binary gcd, one step a cycle
				if (g_fin_c) begin
					dv_q  <= g_val_c;
					rmn_q <= '0;
					rmd_q <= '0;
					cnt_q <= '1;
				end else if (!ga_q[0] && !gb_q[0]) begin
					ga_q <= ga_q >> 1;
					gb_q <= gb_q >> 1;
					gk_q <= gk_q + 6'd1;
				end else if (!ga_q[0]) begin
					ga_q <= ga_q >> 1;
				end else if (!gb_q[0]) begin
					gb_q <= gb_q >> 1;
				end else if (ga_q >= gb_q) begin
					ga_q <= ga_q - gb_q;
				end else begin
					gb_q <= gb_q - ga_q;
				end
			end
			D_DIV: begin
				{rmn_q, qn_q} <= dstep_n_c;
				{rmd_q, qd_q} <= dstep_d_c;
				cnt_q         <= cnt_q - 6'd1;
			end
			default: ;
		endcase
	end

	assign out_data = out_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> st_q == D_IDLE) else $error("command issued while datapath busy");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == D_DIV |-> dv_q != '0) else $error("divide by zero gcd");
	a_gcd_live: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == D_GCD |-> (ga_q != '0 || gb_q != '0)) else $error("gcd of zero pair");

endmodule
`default_nettype wire

// File: src/r2ss_ctrl.sv
`default_nettype none
module r2ss_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output r2ss_pkg::dp_cmd_t       cmd,
	input  wire r2ss_pkg::dp_stat_t stat
);
	import r2ss_pkg::*;

	localparam logic [1:0] C_IDLE  = 2'd0;
	localparam logic [1:0] C_ISSUE = 2'd1;
	localparam logic [1:0] C_WAIT  = 2'd2;

	logic [1:0] st_q;
	logic [5:0] step_q;
	logic       out_valid_q;
	uop_t       uop_c;
	logic       cap_c;

	always_comb begin
		uop_c       = r2ss_prog(step_q);
		cap_c       = (uop_c.op == OP_CAPY) || (uop_c.op == OP_CAPX);
		in_ready    = (st_q == C_IDLE);
		cmd.capture = (st_q == C_IDLE) && in_valid;
		// result register may only be overwritten once the previous result is gone
		cmd.start   = (st_q == C_ISSUE) && !(cap_c && out_valid_q);
		cmd.uop     = uop_c;
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= C_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				C_IDLE: begin
					if (in_valid) begin
						step_q <= '0;
						st_q   <= C_ISSUE;
					end
				end
				C_ISSUE: begin
					if (cmd.start) begin
						st_q <= C_WAIT;
					end
				end
				C_WAIT: begin
					if (stat.done) begin
						if (step_q == LAST_STEP) begin
							st_q        <= C_IDLE;
							out_valid_q <= 1'b1;
						end else begin
							step_q <= step_q + 6'd1;
							st_q   <= C_ISSUE;
						end
					end
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end

	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> st_q == C_WAIT) else $error("unexpected datapath done");
	a_cap_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start && cap_c |-> !out_valid_q) else $error("result overwritten");
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(st_q) == C_WAIT && $past(step_q) == LAST_STEP)
		else $error("result raised out of sequence");

endmodule
`default_nettype wire

// File: src/rational_2x2_system_solver.sv
`default_nettype none
// Solves a1*x + b1*y = c1, a2*x + b2*y = c2 over signed fractions, giving x and y
// in lowest terms with the sign on the numerator (a zero denominator is passed on
// unreduced), a kind code (unique, parallel, same line) and an overflow flag when a
// result leaves 32-bit range. One system is worked at a time by a micro-sequenced
// datapath around a 32x64-bit register file: 12 loads, 23 multiplies, 3 subtracts,
// 2 wraps and 9 fraction reductions. Every operation passes an issue state and a
// register read state before it executes; multiplies sum three 32x32 partial
// products. Each reduction with a non-zero denominator runs a binary gcd loop
// (one step per cycle) followed by a restoring divide of numerator and
// denominator by the gcd in parallel; with a zero denominator it skips both and
// writes the fraction back directly. The next system is accepted once the
// current one has finished; a finished result waits in its own register until
// transferred, and the following system stalls before its result capture meanwhile.
module rational_2x2_system_solver (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire r2ss_pkg::in_item_t   in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output r2ss_pkg::out_item_t       out_data
);
	import r2ss_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	r2ss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	r2ss_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (out_data)
	);

endmodule
`default_nettype wire

// File: tb/tb_checker.sv
`default_nettype none
module tb_checker (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_ready,
	input  wire r2ss_pkg::in_item_t  in_data,
	input  wire logic                out_valid,
	input  wire logic                out_ready,
	input  wire r2ss_pkg::out_item_t out_data,
	output int                       n_errors,
	output int                       n_pending
);
	import r2ss_pkg::*;

	out_item_t solutions_q[$];

	function automatic logic signed [63:0] abs64(input logic signed [63:0] v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic logic [63:0] gcd64(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	// lowest terms, sign on the numerator; zero denominator left alone
	function automatic void reduce_frac(inout logic signed [63:0] n,
			inout logic signed [63:0] d);
		logic        neg;
		logic [63:0] an, ad, g;
		neg = (n < 0) != (d < 0);
		an = abs64(n);
		ad = abs64(d);
		if (ad != 0) begin
			g = gcd64(an, ad);
			an = an / g;
			ad = ad / g;
		end
		n = neg ? -$signed(an) : $signed(an);
		d = $signed(ad);
	endfunction

	function automatic logic signed [63:0] wrap32(input logic signed [63:0] v);
		return {{32{v[31]}}, v[31:0]};
	endfunction

	function automatic logic beyond32(input logic signed [63:0] n, input logic signed [63:0] d);
		return n < -64'sh8000_0000 || n > 64'sh7FFF_FFFF || d > 64'sh7FFF_FFFF;
	endfunction

	function automatic out_item_t solve_system(input in_item_t s);
		logic signed [63:0] a1n, a1d, b1n, b1d, c1n, c1d, a2n, a2d, b2n, b2d, c2n, c2d;
		logic signed [63:0] pn, pd, qn, qd, tn, td, bn, bd, yn, yd, ryn, ryd, xn, xd;
		logic               ovf;
		out_item_t          r;
		a1n = s.a1_num; a1d = {57'd0, s.a1_den};
		b1n = s.b1_num; b1d = {57'd0, s.b1_den};
		c1n = s.c1_num; c1d = {57'd0, s.c1_den};
		a2n = s.a2_num; a2d = {57'd0, s.a2_den};
		b2n = s.b2_num; b2d = {57'd0, s.b2_den};
		c2n = s.c2_num; c2d = {57'd0, s.c2_den};
		ovf = 1'b0;
		pn = a2n * c1n; pd = c1d * a2d; reduce_frac(pn, pd);
		qn = a1n * c2n; qd = a1d * c2d; reduce_frac(qn, qd);
		tn = pn * qd - qn * pd; td = pd * qd; reduce_frac(tn, td);
		pn = b1n * a2n; pd = b1d * a2d; reduce_frac(pn, pd);
		qn = a1n * b2n; qd = a1d * b2d; reduce_frac(qn, qd);
		bn = pn * qd - qn * pd; bd = pd * qd; reduce_frac(bn, bd);
		yn = tn * bd; yd = td * bn; reduce_frac(yn, yd);
		if (beyond32(yn, yd)) ovf = 1'b1;
		yn = wrap32(yn); yd = wrap32(yd);
		ryn = b1n * yn; ryd = b1d * yd; reduce_frac(ryn, ryd);
		xn = a1d * (c1n * ryd - c1d * ryn);
		xd = a1n * c1d * ryd;
		reduce_frac(xn, xd);
		if (beyond32(xn, xd)) ovf = 1'b1;
		xn = wrap32(xn); xd = wrap32(xd);
		r.x_num = xn[31:0];
		r.x_den = xd[30:0];
		r.y_num = yn[31:0];
		r.y_den = yd[30:0];
		r.kind = KIND_UNIQUE;
		if (xd == 0 && yd == 0)
			r.kind = (xn == 0 && yn == 0) ? KIND_SAME : KIND_PARALLEL;
		r.overflow = ovf;
		return r;
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		n_errors++;
	endtask

	initial n_errors = 0;
	assign n_pending = solutions_q.size();

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && in_valid && in_ready)
			solutions_q.push_back(solve_system(in_data));
		if (arst_n && out_valid && out_ready) begin
			if (solutions_q.size() == 0) begin
				report("unexpected result transfer", 64'd1, 64'd0);
			end else begin
				want = solutions_q.pop_front();
				if (out_data.x_num !== want.x_num) report("x_num", out_data.x_num, want.x_num);
				if (out_data.x_den !== want.x_den) report("x_den", out_data.x_den, want.x_den);
				if (out_data.y_num !== want.y_num) report("y_num", out_data.y_num, want.y_num);
				if (out_data.y_den !== want.y_den) report("y_den", out_data.y_den, want.y_den);
				if (out_data.kind !== want.kind) report("kind", out_data.kind, want.kind);
				if (out_data.overflow !== want.overflow)
					report("overflow", out_data.overflow, want.overflow);
			end
		end
	end
endmodule
`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none
module tb_top;
	import r2ss_pkg::*;

	localparam int N_RANDOM   = 430;
	localparam int IDLE_LIMIT = 40000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;
	int        n_errors, n_pending;
	logic      hold_off = 1'b0;
	int        idle_cycles = 0;

	always #5 clk = ~clk;

	rational_2x2_system_solver dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	tb_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.n_errors(n_errors), .n_pending(n_pending)
	);

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(20, 200);
		return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
	endfunction

	function automatic logic [7:0] rand_num();
		case ($urandom_range(0, 9))
			0: return 8'sd0;
			1: return 8'sd99;
			2: return -8'sd99;
			3: return 8'($urandom);
			default: return 8'($signed($urandom_range(0, 198)) - 99);
		endcase
	endfunction

	function automatic logic [6:0] rand_den();
		case ($urandom_range(0, 9))
			0: return 7'd1;
			1: return 7'd99;
			2: return 7'($urandom);
			default: return 7'($urandom_range(1, 99));
		endcase
	endfunction

	function automatic in_item_t rand_system();
		in_item_t s;
		s.a1_num = rand_num(); s.a1_den = rand_den();
		s.b1_num = rand_num(); s.b1_den = rand_den();
		s.c1_num = rand_num(); s.c1_den = rand_den();
		s.a2_num = rand_num(); s.a2_den = rand_den();
		s.b2_num = rand_num(); s.b2_den = rand_den();
		s.c2_num = rand_num(); s.c2_den = rand_den();
		// make a share singular: copy the first left side, at random the right too
		if ($urandom_range(0, 5) == 0) begin
			s.a2_num = s.a1_num; s.a2_den = s.a1_den;
			s.b2_num = s.b1_num; s.b2_den = s.b1_den;
			if ($urandom_range(0, 1)) begin
				s.c2_num = s.c1_num; s.c2_den = s.c1_den;
			end
		end
		return s;
	endfunction

	function automatic in_item_t mk_sys(input int a1n, a1d, b1n, b1d, c1n, c1d,
			input int a2n, a2d, b2n, b2d, c2n, c2d);
		in_item_t s;
		s.a1_num = 8'(a1n); s.a1_den = 7'(a1d);
		s.b1_num = 8'(b1n); s.b1_den = 7'(b1d);
		s.c1_num = 8'(c1n); s.c1_den = 7'(c1d);
		s.a2_num = 8'(a2n); s.a2_den = 7'(a2d);
		s.b2_num = 8'(b2n); s.b2_den = 7'(b2d);
		s.c2_num = 8'(c2n); s.c2_den = 7'(c2d);
		return s;
	endfunction

	task automatic send(input in_item_t s);
		in_valid <= 1'b1;
		in_data <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_gap(input in_item_t s);
		int g;
		send(s);
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// receiver: random stalls; long hold-off when asked
	always @(posedge clk) begin
		if (hold_off)
			out_ready <= 1'b0;
		else if ($urandom_range(0, 39) == 0)
			out_ready <= 1'b0;
		else if (!out_ready)
			out_ready <= ($urandom_range(0, 3) == 0);
		else
			out_ready <= ($urandom_range(0, 4) != 0);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_gap(mk_sys(1, 1, 1, 1, 3, 1, 1, 1, -1, 1, 1, 1));
		send_gap(mk_sys(99, 1, -99, 1, 99, 99, -99, 99, 99, 1, -99, 1));
		send_gap(mk_sys(-99, 99, 99, 99, -99, 1, 99, 1, -99, 99, 99, 1));
		send_gap(mk_sys(-128, 127, 127, 127, -128, 1, 127, 1, -128, 127, 127, 1));
		// parallel lines and coincident lines
		send_gap(mk_sys(1, 2, 1, 3, 1, 1, 1, 2, 1, 3, 2, 1));
		send_gap(mk_sys(2, 3, -5, 7, 4, 9, 2, 3, -5, 7, 4, 9));
		send_gap(mk_sys(0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0, 1));
		// zero x coefficient, zero right-hand sides
		send_gap(mk_sys(0, 1, 1, 1, 5, 1, 1, 1, 1, 1, 7, 1));
		send_gap(mk_sys(3, 4, 5, 6, 0, 1, 7, 8, 9, 10, 0, 1));
		// zero input denominators
		send_gap(mk_sys(1, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1));
		send_gap(mk_sys(1, 1, 1, 0, 1, 1, 1, 1, 2, 1, 1, 0));
		send_gap(mk_sys(5, 0, 7, 0, 3, 0, 2, 0, 1, 0, 9, 0));
		// large primes to push the wrap
		send_gap(mk_sys(97, 89, 83, 79, 73, 71, 67, 61, 59, 53, 47, 43));
		send_gap(mk_sys(-97, 97, 89, 95, -83, 91, 79, 93, -73, 89, 71, 87));
		send_gap(mk_sys(1, 97, 1, 89, 97, 1, 1, 83, 1, 79, 89, 1));
		// the sender waits until everything has come back
		in_valid <= 1'b0;
		while (n_pending != 0) @(posedge clk);
		// receiver holds off while the sender keeps offering
		hold_off <= 1'b1;
		fork
			begin
				repeat (3000) @(posedge clk);
				hold_off <= 1'b0;
			end
			for (int i = 0; i < 6; i++) send(rand_system());
		join
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i < 60) send(rand_system());
			else send_gap(rand_system());
		end
		in_valid <= 1'b0;
		while (n_pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
